### sv/plr_pkg.sv
package plr_pkg;

    // Default tile coordinate width (tile is 2^COORD_BITS pixels on a side)
    localparam int COORD_BITS_DEF = 6;

    // Width of the coordinate fields at the ports
    localparam int PIX_W = 6;

    // Depth of the job queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // Request type codes
    localparam logic REQ_PRESS  = 1'b0;
    localparam logic REQ_MOTION = 1'b1;

endpackage

### sv/plr_front.sv
module plr_front
    import plr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int JOB_W      = 4 * COORD_BITS + 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  logic             req_type,
    input  logic             button_held,
    input  logic [PIX_W-1:0] point_x,
    input  logic [PIX_W-1:0] point_y,
    input  logic             job_ready,
    output logic             job_push,
    output logic [JOB_W-1:0] job_data
);

    localparam int CB = COORD_BITS;
    localparam int CW = COORD_BITS + 1;

    typedef struct packed {
        logic          major_x;
        logic          minor_neg;
        logic [CB-1:0] a0;
        logic [CB-1:0] b0;
        logic [CW-1:0] den;
        logic [CW-1:0] step;
    } job_t;

    logic [CB-1:0] pen_x_reg, pen_x_next;
    logic [CB-1:0] pen_y_reg, pen_y_next;

    logic [CB-1:0] px, py;
    logic [CB-1:0] xa, ya, xb, yb;
    logic          swap_x;
    logic          dy_neg;
    logic [CB-1:0] ady;
    logic [CW-1:0] w, h, hh_mag;
    logic          accept, draws;
    job_t          job;

    assign px = point_x[CB-1:0];
    assign py = point_y[CB-1:0];

    // Order endpoints so that the left one comes first
    assign swap_x = pen_x_reg > px;
    assign xa     = swap_x ? px : pen_x_reg;
    assign ya     = swap_x ? py : pen_y_reg;
    assign xb     = swap_x ? pen_x_reg : px;
    assign yb     = swap_x ? pen_y_reg : py;

    // Extents: w = dx + 1, h = |dy| + 1, negative dy biased by one
    assign dy_neg = yb < ya;
    assign ady    = dy_neg ? CB'(ya - yb) : CB'(yb - ya);
    assign w      = CW'({1'b0, xb} - {1'b0, xa} + CW'(1));
    assign h      = CW'({1'b0, ady} + CW'(1));
    assign hh_mag = dy_neg ? h : {1'b0, ady};

    // Build the job for the back end
    always_comb
    begin
        job = '0;
        if (req_type == REQ_PRESS)
        begin
            job.major_x   = 1'b1;
            job.minor_neg = 1'b0;
            job.a0        = px;
            job.b0        = py;
            job.den       = CW'(1);
            job.step      = '0;
        end
        else if (w > h)
        begin
            job.major_x   = 1'b1;
            job.minor_neg = dy_neg;
            job.a0        = xa;
            job.b0        = ya;
            job.den       = w;
            job.step      = hh_mag;
        end
        else
        begin
            // y-major: run from the lower y endpoint
            job.major_x   = 1'b0;
            job.minor_neg = dy_neg;
            job.a0        = dy_neg ? yb : ya;
            job.b0        = dy_neg ? xb : xa;
            job.den       = h;
            job.step      = w;
        end
    end

    assign req_ready = job_ready;
    assign accept    = req_valid && req_ready;
    assign draws     = (req_type == REQ_PRESS) || button_held;
    assign job_push  = accept && draws;
    assign job_data  = job;

    // Pen position follows every word that draws
    always_comb
    begin
        pen_x_next = pen_x_reg;
        pen_y_next = pen_y_reg;
        if (job_push)
        begin
            pen_x_next = px;
            pen_y_next = py;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg <= '0;
            pen_y_reg <= '0;
        end
        else
        begin
            pen_x_reg <= pen_x_next;
            pen_y_reg <= pen_y_next;
        end
    end

endmodule

### sv/plr_queue.sv
module plr_queue
    import plr_pkg::*;
#(
    parameter int WIDTH = 28,
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             push_ready,
    input  logic             pop,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    count_reg, count_next;

    assign push_ready = count_reg != NW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_reg + 1'b1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_reg + 1'b1);
        if (push && !pop)
            count_next = NW'(count_reg + 1'b1);
        else if (pop && !push)
            count_next = NW'(count_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NW'(DEPTH))
        else $error("queue count over depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (push_ready || pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> pop_valid)
        else $error("queue read while empty");
`endif

endmodule

### sv/plr_back.sv
module plr_back
    import plr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int JOB_W      = 4 * COORD_BITS + 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_valid,
    input  logic [JOB_W-1:0] job_data,
    output logic             job_pop,
    output logic             pix_valid,
    input  logic             pix_ready,
    output logic [PIX_W-1:0] pixel_x,
    output logic [PIX_W-1:0] pixel_y,
    output logic             last_pixel
);

    localparam int CB = COORD_BITS;
    localparam int CW = COORD_BITS + 1;

    typedef struct packed {
        logic          major_x;
        logic          minor_neg;
        logic [CB-1:0] a0;
        logic [CB-1:0] b0;
        logic [CW-1:0] den;
        logic [CW-1:0] step;
    } job_t;

    job_t          job_reg, job_next;
    logic          busy_reg, busy_next;
    logic [CB-1:0] i_reg, i_next;
    logic [CB-1:0] q_reg, q_next;
    logic [CW-1:0] r_reg, r_next;

    logic             out_valid_reg, out_valid_next;
    logic [PIX_W-1:0] out_x_reg, out_x_next;
    logic [PIX_W-1:0] out_y_reg, out_y_next;
    logic             out_last_reg, out_last_next;

    logic          advance;
    logic          at_last;
    logic [CB-1:0] major, minor;
    logic [CW:0]   sum;
    logic          carry;

    // One pixel per cycle while the output register can take it
    assign advance = busy_reg && (!out_valid_reg || pix_ready);
    assign job_pop = !busy_reg && job_valid;

    // Current pixel and the remainder walk for the next one
    assign major   = CB'(job_reg.a0 + i_reg);
    assign minor   = job_reg.minor_neg ? CB'(job_reg.b0 - q_reg) : CB'(job_reg.b0 + q_reg);
    assign at_last = CW'({1'b0, i_reg} + CW'(1)) == job_reg.den;
    assign sum     = {1'b0, r_reg} + {1'b0, job_reg.step};
    assign carry   = sum >= {1'b0, job_reg.den};

    always_comb
    begin
        job_next  = job_reg;
        busy_next = busy_reg;
        i_next    = i_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        if (job_pop)
        begin
            job_next  = job_t'(job_data);
            busy_next = 1'b1;
            i_next    = '0;
            q_next    = '0;
            r_next    = '0;
        end
        else if (advance)
        begin
            i_next = CB'(i_reg + 1'b1);
            if (carry)
            begin
                r_next = CW'(sum - {1'b0, job_reg.den});
                q_next = CB'(q_reg + 1'b1);
            end
            else
                r_next = CW'(sum);
            if (at_last)
                busy_next = 1'b0;
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_last_next  = out_last_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            out_x_next     = PIX_W'(job_reg.major_x ? major : minor);
            out_y_next     = PIX_W'(job_reg.major_x ? minor : major);
            out_last_next  = at_last;
        end
        else if (pix_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        i_reg        <= i_next;
        q_reg        <= q_next;
        r_reg        <= r_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_last_reg <= out_last_next;
    end

    assign pix_valid  = out_valid_reg;
    assign pixel_x    = out_x_reg;
    assign pixel_y    = out_y_reg;
    assign last_pixel = out_last_reg;

`ifndef SYNTHESIS
    a_single_borrow: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (job_reg.step <= job_reg.den))
        else $error("minor step exceeds denominator");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (r_reg < job_reg.den))
        else $error("remainder out of range");

    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> ({1'b0, i_reg} < job_reg.den))
        else $error("pixel index past end of line");
`endif

endmodule

### sv/pen_line_rasterizer_top.sv
// Pen line rasterizer. Each request word is a pen press or a pen motion
// inside a 2^COORD_BITS square tile. A press emits one pixel at the point
// and moves the pen there; a motion with the button held emits the pixels
// of the line from the pen to the point, in walk order, and moves the pen;
// a motion without the button emits nothing. The final pixel of each word
// carries last_pixel. The front end takes one request word per cycle while
// its job queue (QUEUE_DEPTH entries, two by default) has room; the back
// end walks a line one pixel per cycle while pix_ready does not stall it,
// for lines of up to 2^COORD_BITS pixels (64 by default). The back end's
// pixel step, one add and compare per pixel, sets the sustained rate.
module pen_line_rasterizer_top
    import plr_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  logic             req_type,
    input  logic             button_held,
    input  logic [PIX_W-1:0] point_x,
    input  logic [PIX_W-1:0] point_y,
    output logic             pix_valid,
    input  logic             pix_ready,
    output logic [PIX_W-1:0] pixel_x,
    output logic [PIX_W-1:0] pixel_y,
    output logic             last_pixel
);

    localparam int JOB_W = 4 * COORD_BITS + 4;

    logic             push, push_ready;
    logic [JOB_W-1:0] push_data;
    logic             pop, pop_valid;
    logic [JOB_W-1:0] pop_data;

    plr_front #(
        .COORD_BITS (COORD_BITS),
        .JOB_W      (JOB_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_type    (req_type),
        .button_held (button_held),
        .point_x     (point_x),
        .point_y     (point_y),
        .job_ready   (push_ready),
        .job_push    (push),
        .job_data    (push_data)
    );

    plr_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data)
    );

    plr_back #(
        .COORD_BITS (COORD_BITS),
        .JOB_W      (JOB_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (pop_valid),
        .job_data   (pop_data),
        .job_pop    (pop),
        .pix_valid  (pix_valid),
        .pix_ready  (pix_ready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last_pixel (last_pixel)
    );

endmodule

### test/tb_pen_line_rasterizer_top.sv
`timescale 1ns / 100ps

module tb_pen_line_rasterizer_top;
    import plr_pkg::*;

    // One request word as queued for the driver
    typedef struct {
        logic             rtype;
        logic             held;
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] y;
        bit               drain;    // hold off until all pixels are back
    } req_word_t;

    // One expected pixel
    typedef struct {
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] y;
        logic             last;
    } pixel_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             req_valid = 1'b0;
    logic             req_ready;
    logic             req_type = REQ_PRESS;
    logic             button_held = 1'b0;
    logic [PIX_W-1:0] point_x = '0;
    logic [PIX_W-1:0] point_y = '0;
    logic             pix_valid;
    logic             pix_ready = 1'b0;
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic             last_pixel;

    req_word_t        word_q[$];
    pixel_t           pixel_q[$];

    // pen position as the predictor sees it
    logic [PIX_W-1:0] pen_x_m = '0;
    logic [PIX_W-1:0] pen_y_m = '0;

    // pen position as the stimulus generator tracks it
    int               gen_x = 0;
    int               gen_y = 0;

    int               fail_cnt = 0;
    int               tx_gap = 0;
    bit               tx_calm = 1'b0;
    int               rx_stall = 0;
    bit               rx_calm = 1'b0;
    req_word_t        tx_word;
    pixel_t           rx_want;

    pen_line_rasterizer_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_type    (req_type),
        .button_held (button_held),
        .point_x     (point_x),
        .point_y     (point_y),
        .pix_valid   (pix_valid),
        .pix_ready   (pix_ready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .last_pixel  (last_pixel)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic void push_pixel(int x, int y, bit last);
        pixel_t p;
        p.x = x[PIX_W-1:0];
        p.y = y[PIX_W-1:0];
        p.last = last;
        pixel_q.push_back(p);
    endfunction

    // Expected pixels for one accepted word; also moves the pen
    function automatic void rasterize_word(logic rtype, logic held,
                                           logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
        int x1, y1, x2, y2, t, w, h, hh, n;
        if (rtype == REQ_PRESS)
        begin
            push_pixel(px, py, 1'b1);
            pen_x_m = px;
            pen_y_m = py;
        end
        else if (held)
        begin
            x1 = pen_x_m;
            y1 = pen_y_m;
            x2 = px;
            y2 = py;
            if (x1 > x2)
            begin
                t = x1; x1 = x2; x2 = t;
                t = y1; y1 = y2; y2 = t;
            end
            w = x2 - x1 + 1;
            h = y2 - y1;
            hh = h;
            if (h < 0)
            begin
                h = -h;
                hh = hh - 1;   // negative slope is biased down by one
            end
            h = h + 1;
            if (w > h)
            begin
                // shallow: step x
                for (n = 0; n < w; n++)
                    push_pixel(x1 + n, y1 + (n * hh) / w, n == w - 1);
            end
            else
            begin
                // steep: step y with endpoints ordered by y
                if (y1 > y2)
                begin
                    t = x1; x1 = x2; x2 = t;
                    t = y1; y1 = y2; y2 = t;
                    w = -w;
                end
                for (n = 0; n < h; n++)
                    push_pixel(x1 + (n * w) / h, y1 + n, n == h - 1);
            end
            pen_x_m = px;
            pen_y_m = py;
        end
    endfunction

    task automatic check_field(string tag, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, tag, want, got);
            fail_cnt++;
        end
    endtask

    // Queue one word and keep the generator's pen in step
    task automatic add_word(logic rtype, logic held, int x, int y, bit drain);
        req_word_t wd;
        wd.rtype = rtype;
        wd.held = held;
        wd.x = x[PIX_W-1:0];
        wd.y = y[PIX_W-1:0];
        wd.drain = drain;
        word_q.push_back(wd);
        if (rtype == REQ_PRESS || held)
        begin
            gen_x = x;
            gen_y = y;
        end
    endtask

    function automatic int near_coord(int c);
        int v;
        v = c + int'($urandom_range(0, 16)) - 8;
        if (v < 0)
            v = 0;
        if (v > 63)
            v = 63;
        return v;
    endfunction

    // Driver: presents queued words, random gaps between them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid   <= 1'b0;
            req_type    <= REQ_PRESS;
            button_held <= 1'b0;
            point_x     <= '0;
            point_y     <= '0;
            tx_gap = 0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                rasterize_word(req_type, button_held, point_x, point_y);
                if ($urandom_range(0, 31) == 0)
                    tx_calm = !tx_calm;
                tx_gap = tx_calm ? 0 : $urandom_range(0, 7);
            end
            if (!req_valid || req_ready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    req_valid <= 1'b0;
                end
                else if (word_q.size() == 0 || (word_q[0].drain && pixel_q.size() != 0))
                    req_valid <= 1'b0;
                else
                begin
                    tx_word = word_q.pop_front();
                    req_valid   <= 1'b1;
                    req_type    <= tx_word.rtype;
                    button_held <= tx_word.held;
                    point_x     <= tx_word.x;
                    point_y     <= tx_word.y;
                end
            end
        end
    end

    // Monitor: checks each pixel word and stalls at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_ready <= 1'b0;
            rx_stall = 0;
        end
        else
        begin
            if (pix_valid && pix_ready)
            begin
                if (pixel_q.size() == 0)
                begin
                    $display("%0t: unexpected pixel, expected none, got x=%0d y=%0d last=%0d",
                             $time, pixel_x, pixel_y, last_pixel);
                    fail_cnt++;
                end
                else
                begin
                    rx_want = pixel_q.pop_front();
                    check_field("pixel_x", rx_want.x, pixel_x);
                    check_field("pixel_y", rx_want.y, pixel_y);
                    check_field("last_pixel", rx_want.last, last_pixel);
                end
                if ($urandom_range(0, 63) == 0)
                    rx_calm = !rx_calm;
                rx_stall = rx_calm ? 0 : $urandom_range(0, 7);
            end
            if (rx_stall > 0)
            begin
                rx_stall--;
                pix_ready <= 1'b0;
            end
            else
                pix_ready <= 1'b1;
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int counted;
        int r;

        // directed words
        add_word(REQ_PRESS,  1'b0,  0,  0, 1'b0);
        add_word(REQ_PRESS,  1'b1, 63, 63, 1'b0);   // button ignored on press
        add_word(REQ_MOTION, 1'b1,  0,  0, 1'b0);   // full diagonal
        add_word(REQ_MOTION, 1'b1, 63,  0, 1'b0);   // full row
        add_word(REQ_MOTION, 1'b1, 63, 63, 1'b0);   // full column
        add_word(REQ_MOTION, 1'b1,  0, 63, 1'b0);   // row, right to left
        add_word(REQ_MOTION, 1'b0, 10, 20, 1'b0);   // no button: nothing
        add_word(REQ_MOTION, 1'b1, 10, 20, 1'b0);   // steep, reordered by y
        add_word(REQ_MOTION, 1'b1, 10, 20, 1'b0);   // zero length
        add_word(REQ_MOTION, 1'b1, 30, 12, 1'b0);   // shallow, negative dy
        add_word(REQ_MOTION, 1'b1, 40, 14, 1'b0);   // shallow, positive dy
        add_word(REQ_MOTION, 1'b1, 41, 50, 1'b0);   // steep, positive dy
        add_word(REQ_MOTION, 1'b1, 30, 20, 1'b0);   // steep, x swapped
        add_word(REQ_MOTION, 1'b0,  0,  0, 1'b0);
        add_word(REQ_PRESS,  1'b0,  5,  5, 1'b1);
        add_word(REQ_MOTION, 1'b1,  6,  6, 1'b0);   // w equals h
        add_word(REQ_MOTION, 1'b1,  8,  5, 1'b0);   // dy of minus one
        add_word(REQ_MOTION, 1'b1,  0, 63, 1'b0);
        add_word(REQ_MOTION, 1'b1, 63,  0, 1'b0);   // anti-diagonal
        add_word(REQ_PRESS,  1'b0, 42, 21, 1'b0);
        add_word(REQ_MOTION, 1'b1, 21, 42, 1'b0);

        // random strokes, mostly short segments from the pen
        counted = 0;
        while (counted < 440)
        begin
            r = $urandom_range(0, 99);
            if (r < 14)
                add_word(REQ_PRESS, 1'($urandom_range(0, 1)), $urandom_range(0, 63),
                         $urandom_range(0, 63), (counted % 100) == 99);
            else if (r < 22)
                add_word(REQ_MOTION, 1'b0, $urandom_range(0, 63), $urandom_range(0, 63), 1'b0);
            else if (r < 28)
                add_word(REQ_MOTION, 1'b1, $urandom_range(0, 63), $urandom_range(0, 63),
                         1'b0);
            else
                add_word(REQ_MOTION, 1'b1, near_coord(gen_x), near_coord(gen_y), 1'b0);
            counted++;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (word_q.size() != 0 || req_valid)
            @(posedge clk);
        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (fail_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #8000000;
        $display("FAIL");
        $finish;
    end

endmodule
